@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent checks sampled on clk, off while arst_n is low.
`define ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/bmt_pkg.sv @@
package bmt_pkg;

	localparam int WORD_W = 64;

	// register indexes of the configuration port
	localparam logic CFG_NUM_VARS  = 1'b0;
	localparam logic CFG_DIRECTION = 1'b1;

	localparam logic [WORD_W-1:0] HALF_MASK [6] = '{
		64'h5555555555555555,
		64'h3333333333333333,
		64'h0F0F0F0F0F0F0F0F,
		64'h00FF00FF00FF00FF,
		64'h0000FFFF0000FFFF,
		64'h00000000FFFFFFFF
	};

	typedef struct packed {
		logic       ld;      // write input word
		logic       rd;      // read both store ports
		logic       xw;      // write xor of the two read words
		logic       up;      // upward direction
		logic [2:0] passes;  // in-word butterfly passes
	} bmt_cmd_t;

	// in-word butterfly passes, each pass fixed in shift and mask
	function automatic logic [WORD_W-1:0] anf_word(logic [WORD_W-1:0] v,
			logic [2:0] passes, logic up);
		logic [WORD_W-1:0] x;
		x = v;
		for (int i = 0; i < 6; i++) begin
			if (3'(i) < passes) begin
				if (up)
					x = x ^ ((x >> (1 << i)) & HALF_MASK[i]);
				else
					x = x ^ ((x & HALF_MASK[i]) << (1 << i));
			end
		end
		return x;
	endfunction

endpackage

@@ rtl/bmt_datapath.sv @@
module bmt_datapath
	import bmt_pkg::*;
#(
	parameter int AW = 6
) (
	input  logic              clk,
	input  bmt_cmd_t          cmd,
	input  logic [AW-1:0]     wr_addr,
	input  logic [AW-1:0]     rd_addr_a,
	input  logic [AW-1:0]     rd_addr_b,
	input  logic [WORD_W-1:0] table_word,
	output logic [WORD_W-1:0] result_word
);

	logic [WORD_W-1:0] store_q [1 << AW];
	logic [WORD_W-1:0] rd_a_q;
	logic [WORD_W-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (cmd.ld)
			store_q[wr_addr] <= table_word;
		else if (cmd.xw)
			store_q[wr_addr] <= rd_a_q ^ rd_b_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_a_q <= store_q[rd_addr_a];
			rd_b_q <= store_q[rd_addr_b];
		end
	end

	// in-word passes commute with the cross-word xors; apply them on the way out
	assign result_word = anf_word(rd_a_q, cmd.passes, cmd.up);

endmodule

@@ rtl/bmt_ctrl.sv @@
module bmt_ctrl
	import bmt_pkg::*;
#(
	parameter int MAX_VARS = 12,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_write,
	input  logic          cfg_index,
	input  logic [3:0]    cfg_data,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          last_word,
	output bmt_cmd_t      cmd,
	output logic [AW-1:0] wr_addr,
	output logic [AW-1:0] rd_addr_a,
	output logic [AW-1:0] rd_addr_b
);

	typedef enum logic [2:0] {
		S_LOAD,
		S_XRD,
		S_XWR,
		S_ERD,
		S_EOUT
	} state_t;

	state_t        state_q;
	logic [3:0]    nv_q;
	logic          up_q;
	logic [AW:0]   cnt_q;
	logic [2:0]    pass_q;
	logic [AW-1:0] pair_q;
	logic          valid_q;
	logic          last_q;

	logic [AW:0]   words;
	logic [AW-1:0] half;
	logic [3:0]    nx;
	logic [AW-1:0] step;
	logic [AW-1:0] low_mask;
	logic [AW-1:0] lo_w;
	logic [AW-1:0] hi_w;
	logic          in_take;
	logic          cnt_end;

	assign words    = (nv_q < 4'd6) ? (AW+1)'(1) : ((AW+1)'(1) << (nv_q - 4'd6));
	assign half     = words[AW:1];
	assign nx       = (nv_q > 4'd6) ? nv_q - 4'd6 : 4'd0;
	assign step     = AW'(1) << pass_q;
	assign low_mask = step - AW'(1);
	// insert a zero at the pass bit to get the lower word of the pair
	assign lo_w     = ((pair_q & ~low_mask) << 1) | (pair_q & low_mask);
	assign hi_w     = lo_w | step;
	assign in_take  = in_valid && !in_stall;
	assign cnt_end  = (cnt_q + (AW+1)'(1)) == words;

	assign in_stall  = (state_q != S_LOAD);
	assign out_valid = valid_q;
	assign last_word = last_q;

	always_comb begin
		cmd.ld     = 1'b0;
		cmd.rd     = 1'b0;
		cmd.xw     = 1'b0;
		cmd.up     = up_q;
		cmd.passes = (nv_q < 4'd6) ? nv_q[2:0] : 3'd6;
		wr_addr    = cnt_q[AW-1:0];
		rd_addr_a  = lo_w;
		rd_addr_b  = hi_w;
		unique case (state_q)
			S_LOAD: begin
				cmd.ld = in_take;
			end
			S_XRD: begin
				cmd.rd = 1'b1;
			end
			S_XWR: begin
				cmd.xw  = 1'b1;
				wr_addr = up_q ? lo_w : hi_w;
			end
			S_ERD: begin
				cmd.rd    = 1'b1;
				rd_addr_a = cnt_q[AW-1:0];
			end
			S_EOUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			nv_q    <= 4'(MAX_VARS);
			up_q    <= 1'b0;
			cnt_q   <= '0;
			pass_q  <= '0;
			pair_q  <= '0;
			valid_q <= 1'b0;
			last_q  <= 1'b0;
		end else if (cfg_write && cfg_index == CFG_NUM_VARS) begin
			// drop any partly loaded table
			nv_q  <= (cfg_data > 4'(MAX_VARS)) ? 4'(MAX_VARS) : cfg_data;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_take) begin
						if (cnt_end) begin
							cnt_q  <= '0;
							pass_q <= '0;
							pair_q <= '0;
							state_q <= (nx == 4'd0) ? S_ERD : S_XRD;
						end else begin
							cnt_q <= cnt_q + (AW+1)'(1);
						end
					end
				end
				S_XRD: begin
					state_q <= S_XWR;
				end
				S_XWR: begin
					if (pair_q == half - AW'(1)) begin
						pair_q <= '0;
						if ({1'b0, pass_q} == nx - 4'd1) begin
							state_q <= S_ERD;
						end else begin
							pass_q  <= pass_q + 3'd1;
							state_q <= S_XRD;
						end
					end else begin
						pair_q  <= pair_q + AW'(1);
						state_q <= S_XRD;
					end
				end
				S_ERD: begin
					valid_q <= 1'b1;
					last_q  <= cnt_end;
					state_q <= S_EOUT;
				end
				S_EOUT: begin
					// hold the item until the receiver takes it
					if (!out_stall) begin
						valid_q <= 1'b0;
						if (last_q) begin
							cnt_q   <= '0;
							state_q <= S_LOAD;
						end else begin
							cnt_q   <= cnt_q + (AW+1)'(1);
							state_q <= S_ERD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
			if (cfg_write && cfg_index == CFG_DIRECTION)
				up_q <= cfg_data[0];
		end
	end

endmodule

@@ rtl/boolean_moebius_transform.sv @@
// Loading: one item per cycle; words are stored as they arrive.
// After the last word: each of the n-6 cross-word passes over W = 2^(n-6) words reads
// each word pair (S_XRD) and writes back their xor (S_XWR); then the output phase starts.
// Emit: each result word is read (S_ERD) and held (S_EOUT) while out_stall is high; the next
// word is read only once out_stall is low; the in-word passes are applied to each word as it leaves.
// Reset: num_vars = MAX_VARS, direction downward, load count and output valid cleared;
// the word store holds no reset value.
module boolean_moebius_transform
	import bmt_pkg::*;
#(
	parameter int MAX_VARS = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic              cfg_index,
	input  logic [3:0]        cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [WORD_W-1:0] table_word,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [WORD_W-1:0] result_word,
	output logic              last_word
);

	`include "assert_macros.svh"

	localparam int AW = (MAX_VARS > 6) ? MAX_VARS - 6 : 1;

	bmt_cmd_t      cmd;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr_a;
	logic [AW-1:0] rd_addr_b;

	bmt_ctrl #(
		.MAX_VARS (MAX_VARS),
		.AW       (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.last_word (last_word),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b)
	);

	bmt_datapath #(
		.AW (AW)
	) u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.wr_addr     (wr_addr),
		.rd_addr_a   (rd_addr_a),
		.rd_addr_b   (rd_addr_b),
		.table_word  (table_word),
		.result_word (result_word)
	);

	`ASSERT_SAME(a_no_load_while_emit, !in_stall, !out_valid)
	`ASSERT_NEXT(a_last_reopens_input, out_valid && !out_stall && last_word, !in_stall)
	`ASSERT_ALWAYS(a_one_store_op, $onehot0({cmd.ld, cmd.rd, cmd.xw}))

endmodule
